[hw/rtl/mlmf_pkg.sv]
// Shared constants and types for the mirrored line median filter.
// No dependencies.
`timescale 1ns / 1ps
package mlmf_pkg;
   localparam int CFG_ADDR_BITS = 3;
   localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_SIZE = 3'd0;
   localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_LENGTH = 3'd4;
   localparam int WSIZE_BITS = 5;
   localparam int LLEN_BITS = 13;
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 5'd3;
   localparam logic [LLEN_BITS-1:0] LLEN_RESET = 13'd4096;
endpackage

[hw/rtl/mlmf_stream_if.sv]
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface mlmf_stream_if #(parameter int W = 16);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/mlmf_front.sv]
// Front part: window shift register and position tracking; emits one job per
// result position to the back part. Depends on mlmf_pkg.
`timescale 1ns / 1ps
module mlmf_front #(
   parameter int MAX_WINDOW = 25,
   parameter int MAX_LINE = 4096,
   parameter int SAMPLE_BITS = 16,
   parameter int PB = 13
) (
   input  logic clock,
   input  logic reset,
   input  logic [mlmf_pkg::WSIZE_BITS-1:0] wsize,
   input  logic [mlmf_pkg::LLEN_BITS-1:0] llen,
   input  logic restart,
   input  logic in_valid,
   output logic in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic job_valid,
   input  logic job_ready,
   output logic [SAMPLE_BITS-1:0] job_win [MAX_WINDOW+1],
   output logic [PB-1:0] job_p,
   output logic [PB-1:0] job_k,
   output logic [5:0] job_n,
   output logic [PB:0] job_len,
   output logic job_zero,
   output logic job_last
);
   import mlmf_pkg::*;
   localparam int D = MAX_WINDOW + 1;
   logic [SAMPLE_BITS-1:0] win_ff [D];
   logic [PB-1:0] pos_ff, pos_in;
   logic busy_ff, busy_in;
   logic [PB-1:0] p_ff, p_in, fin_ff, fin_in;
   logic zero_ff, zero_in, lastl_ff, lastl_in;
   logic [5:0] n;
   logic [PB:0] len;
   logic [5:0] n2;
   logic last_in_line, take;

   always_comb begin
      n = (wsize == '0) ? 6'd1 : {1'b0, wsize};
      if (32'(n) > MAX_WINDOW) n = 6'(MAX_WINDOW);
      len = (llen == '0) ? (PB+1)'(1) : (PB+1)'(llen);
      if (32'(len) > MAX_LINE) len = (PB+1)'(MAX_LINE);
      n2 = n >> 1;
   end

   assign in_ready = !busy_ff || (job_ready && p_ff == fin_ff);
   assign take = in_valid && in_ready;
   assign last_in_line = ((PB+1)'(pos_ff) + 1'b1) >= len;

   always_comb begin
      busy_in = busy_ff;
      p_in = p_ff;
      fin_in = fin_ff;
      zero_in = zero_ff;
      lastl_in = lastl_ff;
      pos_in = pos_ff;
      if (busy_ff && job_ready) begin
         if (p_ff == fin_ff) busy_in = 1'b0;
         else p_in = p_ff + 1'b1;
      end
      if (take) begin
         pos_in = last_in_line ? '0 : pos_ff + 1'b1;
         lastl_in = last_in_line;
         if (len < (PB+1)'(n)) begin
            busy_in = 1'b1; zero_in = 1'b1; p_in = pos_ff; fin_in = pos_ff;
         end else if (pos_ff >= PB'(n2)) begin
            busy_in = 1'b1; zero_in = 1'b0;
            p_in = pos_ff - PB'(n2);
            fin_in = last_in_line ? pos_ff : pos_ff - PB'(n2);
         end
      end
      if (restart) begin
         pos_in = '0;
         busy_in = 1'b0;
      end
   end

   logic [PB-1:0] k_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         busy_ff <= busy_in;
      end
      p_ff <= p_in;
      fin_ff <= fin_in;
      zero_ff <= zero_in;
      lastl_ff <= lastl_in;
      if (take) begin
         k_ff <= pos_ff;
         win_ff[0] <= in_sample;
         for (int i = 1; i < D; i++) win_ff[i] <= win_ff[i-1];
      end
   end

   assign job_valid = busy_ff;
   assign job_win = win_ff;
   assign job_p = p_ff;
   assign job_k = k_ff;
   assign job_n = n;
   assign job_len = len;
   assign job_zero = zero_ff;
   assign job_last = lastl_ff && (p_ff == fin_ff);
endmodule

[hw/rtl/mlmf_back.sv]
// Back part: gathers the mirrored window, ranks it over three registered
// stages and holds the result. Depends on mlmf_pkg.
`timescale 1ns / 1ps
module mlmf_back #(
   parameter int MAX_WINDOW = 25,
   parameter int SAMPLE_BITS = 16,
   parameter int PB = 13
) (
   input  logic clock,
   input  logic reset,
   input  logic flush,
   input  logic job_valid,
   output logic job_ready,
   input  logic [SAMPLE_BITS-1:0] job_win [MAX_WINDOW+1],
   input  logic [PB-1:0] job_p,
   input  logic [PB-1:0] job_k,
   input  logic [5:0] job_n,
   input  logic [PB:0] job_len,
   input  logic job_zero,
   input  logic job_last,
   output logic out_valid,
   input  logic out_ready,
   output logic [SAMPLE_BITS-1:0] out_median,
   output logic out_last
);
   import mlmf_pkg::*;
   localparam int D = MAX_WINDOW + 1;
   localparam int CB = $clog2(D + 1);
   // stage a: gathered window
   logic a_v_ff, b_v_ff, o_v_ff;
   logic [SAMPLE_BITS-1:0] a_buf_ff [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] a_use_ff;
   logic [5:0] a_n2_ff, b_n2_ff;
   logic a_zero_ff, a_last_ff, b_zero_ff, b_last_ff;
   logic [SAMPLE_BITS-1:0] b_buf_ff [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] b_use_ff;
   logic [CB-1:0] b_lt_ff [MAX_WINDOW];
   logic [CB-1:0] b_le_ff [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] o_med_ff;
   logic o_last_ff;
   logic adv_o, adv_b, adv_a;
   logic [SAMPLE_BITS-1:0] g [MAX_WINDOW];
   logic [MAX_WINDOW-1:0] gu;

   assign adv_o = !o_v_ff || out_ready;
   assign adv_b = !b_v_ff || adv_o;
   assign adv_a = !a_v_ff || adv_b;
   assign job_ready = adv_a;

   always_comb begin
      logic signed [PB+2:0] q;
      logic [PB:0] idx;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         q = $signed({3'b0, job_p}) - $signed((PB+3)'(job_n >> 1)) + $signed((PB+3)'(j));
         if (q < 0) q = -q - $signed((PB+3)'(1));
         if (q > $signed({2'b0, job_len}) - $signed((PB+3)'(1)))
            q = $signed({1'b0, job_len, 1'b0}) - $signed((PB+3)'(1)) - q;
         if (q < 0) q = '0;
         idx = (PB+1)'(job_k) - (PB+1)'(q);
         gu[j] = (j < 32'(job_n));
         g[j] = (idx < (PB+1)'(D)) ? job_win[idx[$clog2(D)-1:0]] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; o_v_ff <= 1'b0;
      end else begin
         if (adv_a) a_v_ff <= job_valid;
         if (adv_b) b_v_ff <= a_v_ff;
         if (adv_o) o_v_ff <= b_v_ff;
      end
      if (adv_a) begin
         a_buf_ff <= g; a_use_ff <= gu; a_n2_ff <= job_n >> 1;
         a_zero_ff <= job_zero; a_last_ff <= job_last;
      end
      if (adv_b) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            logic [CB-1:0] lt, le;
            lt = '0; le = '0;
            for (int j = 0; j < MAX_WINDOW; j++) begin
               if (a_use_ff[j] && a_buf_ff[j] < a_buf_ff[i]) lt = lt + 1'b1;
               if (a_use_ff[j] && a_buf_ff[j] <= a_buf_ff[i]) le = le + 1'b1;
            end
            b_lt_ff[i] <= lt; b_le_ff[i] <= le;
         end
         b_buf_ff <= a_buf_ff; b_use_ff <= a_use_ff; b_n2_ff <= a_n2_ff;
         b_zero_ff <= a_zero_ff; b_last_ff <= a_last_ff;
      end
      if (adv_o) begin
         logic [SAMPLE_BITS-1:0] m;
         m = '0;
         for (int i = 0; i < MAX_WINDOW; i++)
            if (b_use_ff[i] && CB'(b_n2_ff) >= b_lt_ff[i] && CB'(b_n2_ff) < b_le_ff[i])
               m = b_buf_ff[i];
         o_med_ff <= b_zero_ff ? '0 : m;
         o_last_ff <= b_last_ff;
      end
   end

   assign out_valid = o_v_ff;
   assign out_median = o_med_ff;
   assign out_last = o_last_ff;
endmodule

[hw/rtl/mirrored_line_median_filter.sv]
// Top level of the mirrored line median filter.
// Depends on mlmf_pkg, mlmf_stream_if, mlmf_front and mlmf_back.
`timescale 1ns / 1ps
// Accepts one sample per cycle and gives one median per cycle when not stalled;
// after the last sample of a line the next request is held while the front
// issues one job per flushed position.
// A job passes the gather, rank and select/output registers before its result
// is valid; a stalled result holds the pipeline back to the input. A register
// write restarts the line; write only while no request is in flight.
module mirrored_line_median_filter #(
   parameter int MAX_WINDOW = 25,
   parameter int MAX_LINE = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   mlmf_stream_if.sink req_chan,
   mlmf_stream_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [mlmf_pkg::CFG_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import mlmf_pkg::*;
   localparam int PB = $clog2(MAX_LINE + 1);
   localparam int D = MAX_WINDOW + 1;
   logic [WSIZE_BITS-1:0] wsize_ff;
   logic [LLEN_BITS-1:0] llen_ff;
   logic wr;
   logic jv, jr, jz, jl;
   logic [SAMPLE_BITS-1:0] jw [D];
   logic [PB-1:0] jp, jk;
   logic [5:0] jn;
   logic [PB:0] jlen;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      case (csr_paddr)
         REG_WINDOW_SIZE: csr_prdata = 32'(wsize_ff);
         REG_LINE_LENGTH: csr_prdata = 32'(llen_ff);
         default: csr_prdata = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= WSIZE_RESET;
         llen_ff <= LLEN_RESET;
      end else if (wr) begin
         if (csr_paddr == REG_WINDOW_SIZE) wsize_ff <= csr_pwdata[WSIZE_BITS-1:0];
         if (csr_paddr == REG_LINE_LENGTH) llen_ff <= csr_pwdata[LLEN_BITS-1:0];
      end
   end

   mlmf_front #(.MAX_WINDOW(MAX_WINDOW), .MAX_LINE(MAX_LINE),
      .SAMPLE_BITS(SAMPLE_BITS), .PB(PB)) u_front (
      .clock, .reset, .wsize(wsize_ff), .llen(llen_ff),
      .restart(wr && (csr_paddr == REG_WINDOW_SIZE || csr_paddr == REG_LINE_LENGTH)),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready),
      .in_sample(req_chan.data[SAMPLE_BITS-1:0]),
      .job_valid(jv), .job_ready(jr), .job_win(jw), .job_p(jp), .job_k(jk),
      .job_n(jn), .job_len(jlen), .job_zero(jz), .job_last(jl));

   mlmf_back #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .PB(PB)) u_back (
      .clock, .reset, .flush(1'b0),
      .job_valid(jv), .job_ready(jr), .job_win(jw), .job_p(jp), .job_k(jk),
      .job_n(jn), .job_len(jlen), .job_zero(jz), .job_last(jl),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready),
      .out_median(rsp_chan.data[SAMPLE_BITS-1:0]), .out_last(rsp_chan.data[SAMPLE_BITS]));
endmodule

[hw/rtl/mlmf_checker.sv]
// Port-level checks for the mirrored line median filter, bound to the top.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module mlmf_checker #(
   parameter int W = 17
) (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [W-1:0] rsp_data,
   input logic csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_rdy: assert property (@(posedge clock) csr_pready) else $error("pready low");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid) else $error("valid after reset");
endmodule

bind mirrored_line_median_filter mlmf_checker #(.W(SAMPLE_BITS + 1)) u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_data(rsp_chan.data[SAMPLE_BITS:0]), .csr_pready(csr_pready));
